/* rtl/fwdf_pkg.sv */
// shared types and constants for the fixed-width decimal formatter
package fwdf_pkg;

    localparam int VALUE_W       = 31;
    localparam int WIDTH_W       = 5;
    localparam int POINT_W       = 5;
    localparam int CHAR_W        = 8;
    localparam int POS_W         = 4;
    localparam int BCD_DIGITS    = 10;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int MAX_WIDTH_DEF = 16;
    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 16;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
    localparam logic [CHAR_W-1:0] FILL_RESET = 8'h20;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_RUN,
        CONV_DONE
    } conv_state_t;

    // converted value plus the field description, handed to the emitter
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [WIDTH_W-1:0] width;
        logic               has_point;
        logic [POINT_W-2:0] pd;
    } conv_result_t;

endpackage

/* rtl/fwdf_conv.sv */
// bit-serial binary to bcd converter (shift and add-3), one input bit per cycle
module fwdf_conv #(
    parameter int MAX_WIDTH = fwdf_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [fwdf_pkg::VALUE_W-1:0]    in_value,
    input  logic [fwdf_pkg::WIDTH_W-1:0]    in_width,
    input  logic [fwdf_pkg::POINT_W-1:0]    in_point,
    output logic                            res_valid,
    input  logic                            res_ready,
    output fwdf_pkg::conv_result_t          res
);
    import fwdf_pkg::*;

    localparam int WIDTH_MAX_FIELD = (1 << WIDTH_W) - 1;
    localparam int EFF_MAX = (MAX_WIDTH > WIDTH_MAX_FIELD) ? WIDTH_MAX_FIELD : MAX_WIDTH;
    localparam logic [WIDTH_W-1:0] EFF_MAX_W = WIDTH_W'(EFF_MAX);
    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    conv_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic                 hp_reg, hp_next;
    logic [POINT_W-2:0]   pd_reg, pd_next;

    logic [WIDTH_W-1:0]   width_sat;
    logic [BCD_W-1:0]     bcd_adj;

    assign width_sat = (in_width > EFF_MAX_W) ? EFF_MAX_W : in_width;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        width_reg <= width_next;
        hp_reg    <= hp_next;
        pd_reg    <= pd_next;
    end

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        width_next = width_reg;
        hp_next    = hp_reg;
        pd_next    = pd_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            CONV_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    bin_next   = in_value;
                    bcd_next   = '0;
                    cnt_next   = CNT_LAST;
                    width_next = width_sat;
                    hp_next    = ~in_point[POINT_W-1];
                    pd_next    = in_point[POINT_W-2:0];
                    // a zero-width field produces nothing
                    if (width_sat != '0) begin
                        state_next = CONV_RUN;
                    end
                end
            end
            CONV_RUN: begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = CONV_DONE;
                end
            end
            CONV_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = CONV_IDLE;
                end
            end
            default: state_next = CONV_IDLE;
        endcase
    end

    assign res.bcd       = bcd_reg;
    assign res.width     = width_reg;
    assign res.has_point = hp_reg;
    assign res.pd        = pd_reg;

endmodule

/* rtl/fwdf_emit.sv */
// character emitter: shifts one bcd digit out per digit character, rightmost first
module fwdf_emit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [fwdf_pkg::CHAR_W-1:0]     fill_char,
    input  logic                            res_valid,
    output logic                            res_ready,
    input  fwdf_pkg::conv_result_t          res,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fwdf_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import fwdf_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  tvalid_reg, tvalid_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [WIDTH_W-1:0]    k_reg, k_next;
    logic [WIDTH_W-1:0]    w_reg, w_next;
    logic                  hp_reg, hp_next;
    logic [POINT_W-2:0]    pd_reg, pd_next;
    logic [M_TDATA_W-1:0]  tdata_reg, tdata_next;
    logic                  tlast_reg, tlast_next;

    logic                  advance;
    logic                  at_point;
    logic                  lead_digit;
    logic [WIDTH_W-1:0]    w_last;
    logic [WIDTH_W-1:0]    pos_full;
    logic [CHAR_W-1:0]     ch;
    logic                  take_digit;

    assign res_ready  = ~busy_reg;
    assign advance    = busy_reg && (!tvalid_reg || m_tready);
    assign at_point   = hp_reg && (k_reg == {1'b0, pd_reg});
    assign lead_digit = hp_reg && (k_reg < {1'b0, pd_reg});
    assign w_last     = w_reg - 1'b1;
    assign pos_full   = w_last - k_reg;
    assign take_digit = !at_point && ((|bcd_reg) || lead_digit);

    always_comb begin
        if (at_point) begin
            ch = CH_POINT;
        end else if (take_digit) begin
            ch = CH_ZERO | {4'b0, bcd_reg[3:0]};
        end else begin
            ch = fill_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            tvalid_reg <= tvalid_next;
        end
        bcd_reg   <= bcd_next;
        k_reg     <= k_next;
        w_reg     <= w_next;
        hp_reg    <= hp_next;
        pd_reg    <= pd_next;
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    always_comb begin
        busy_next   = busy_reg;
        tvalid_next = tvalid_reg;
        bcd_next    = bcd_reg;
        k_next      = k_reg;
        w_next      = w_reg;
        hp_next     = hp_reg;
        pd_next     = pd_reg;
        tdata_next  = tdata_reg;
        tlast_next  = tlast_reg;

        if (tvalid_reg && m_tready) begin
            tvalid_next = 1'b0;
        end

        if (advance) begin
            tvalid_next = 1'b1;
            tdata_next  = {{(M_TDATA_W - POS_W - CHAR_W){1'b0}}, pos_full[POS_W-1:0], ch};
            tlast_next  = (k_reg == w_last);
            k_next      = k_reg + 1'b1;
            if (take_digit) begin
                bcd_next = {4'b0, bcd_reg[BCD_W-1:4]};
            end
            if (k_reg == w_last) begin
                busy_next = 1'b0;
            end
        end else if (!busy_reg && res_valid) begin
            busy_next = 1'b1;
            bcd_next  = res.bcd;
            k_next    = '0;
            w_next    = res.width;
            hp_next   = res.has_point;
            pd_next   = res.pd;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

/* rtl/fixed_width_decimal_formatter_unit.sv */
// top level of the fixed-width decimal formatter
// Formats a 31-bit unsigned value as the ASCII characters of a field of 1 to
// MAX_WIDTH positions (wider requests are cut to MAX_WIDTH, zero width gives
// nothing). Characters leave rightmost position first, one transfer each,
// with the field position in tdata and tlast on position 0. A decimal point
// sits point_digits positions from the right (negative means no point, a
// value at or beyond the width means none either); positions right of the
// point are always digits, positions left of it are digits while value
// remains and then the fill character, and digits that do not fit are lost.
// The fill character comes from a single write-only register, space after
// reset, to be written only while the block is idle.
// Timing: the value is first turned into ten bcd digits by a shift-and-add-3
// converter that takes one input bit per cycle. Characters then go out at
// one per cycle from the output register while the sink does not stall, and
// conversion of the next item runs while the previous field goes out.
module fixed_width_decimal_formatter_unit #(
    parameter int MAX_WIDTH = fwdf_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // fill character register
    input  logic                            cfg_we,
    input  logic [fwdf_pkg::CHAR_W-1:0]     cfg_wdata,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [30:0] value, [35:31] width, [40:36] point_digits, [47:41] zero
    input  logic [fwdf_pkg::S_TDATA_W-1:0]  s_tdata,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] char_code, [11:8] position, [15:12] zero
    output logic [fwdf_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import fwdf_pkg::*;

    logic [CHAR_W-1:0] fill_reg, fill_next;

    // converter to emitter handoff
    logic         res_valid;
    logic         res_ready;
    conv_result_t res;

    // fill character register, to be written only while idle; not enforced
    always_comb begin
        fill_next = fill_reg;
        if (cfg_we) begin
            fill_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= FILL_RESET;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // binary to bcd, one bit per cycle
    fwdf_conv #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .in_width  (s_tdata[VALUE_W +: WIDTH_W]),
        .in_point  (s_tdata[VALUE_W + WIDTH_W +: POINT_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // one character per cycle into the output register when not stalled
    fwdf_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fill_char (fill_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
